// File: rtl/lss_pkg.sv
// ============================================================================
// Line sensor steering - shared package
// Types, codes and fixed widths used across the steering controller files.
// ============================================================================
package lss_pkg;

    // Frame geometry
    localparam int CHANNELS = 5;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int ADC_BITS = 10;
    localparam int RD_W     = ADC_BITS;

    // Field and register widths
    localparam int THR_W    = 10;
    localparam int SWT_W    = 12;
    localparam int SPEED_W  = 8;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PWM_W    = 8;
    localparam int SPD_W    = SPEED_W + 1;
    localparam int POS_W    = 5;
    localparam int TRM_W    = POS_W + 1;
    localparam int ACC_W    = 25;

    // Stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = 7;

    // Register reset values
    localparam logic [THR_W-1:0]   RST_LINE_THR = 10'd450;
    localparam logic [SWT_W-1:0]   RST_SWT_THR  = 12'd2000;
    localparam logic [SPEED_W-1:0] RST_MAX_SPD  = 8'd80;
    localparam logic [SPEED_W-1:0] RST_FWD_SPD  = 8'd40;
    localparam logic [SPEED_W-1:0] RST_SPIN_SPD = 8'd40;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P   = 16'd384;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D   = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I   = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_THR,
        CFG_SWT_THR,
        CFG_MAX_SPD,
        CFG_FWD_SPD,
        CFG_SPIN_SPD,
        CFG_GAIN_P,
        CFG_GAIN_D,
        CFG_GAIN_I
    } t_cfg_idx;

    typedef enum logic [IN_TUSER_W-1:0] {
        CMD_CAL_START,
        CMD_CAL_SAMPLE,
        CMD_CAL_FINISH,
        CMD_RUN
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_LOAD,
        ST_DIV,
        ST_CENT,
        ST_CDIV,
        ST_PID,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0]   line_thr;
        logic [SWT_W-1:0]   switch_thr;
        logic [SPEED_W-1:0] max_speed;
        logic [SPEED_W-1:0] fwd_speed;
        logic [SPEED_W-1:0] spin_speed;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAIN_W-1:0]  gain_i;
    } t_cfg;

    typedef logic [CHANNELS-1:0][RD_W-1:0] t_frame;

    typedef struct packed {
        logic             dir;
        logic [PWM_W-1:0] pwm;
    } t_drive;

    typedef struct packed {
        t_drive           left;
        t_drive           right;
        logic [POS_W-1:0] line_position;
        logic             line_found;
        logic             dark_line_mode;
    } t_result;

endpackage

// File: rtl/lss_div.sv
// ============================================================================
// Line sensor steering - shared divider
// Restoring unsigned divider, one quotient bit per cycle; quotient saturates
// to all ones when it does not fit.
// ============================================================================
module lss_div
    import lss_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 13,
    parameter int QB    = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QB-1:0]    o_quo
);

    localparam int DSR_W = DEN_W + QB;
    localparam int CMP_W = (NUM_W > DSR_W) ? NUM_W : DSR_W;
    localparam int CNT_W = $clog2(QB + 2);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CMP_W-1:0] r_rem;
    logic [CMP_W-1:0] r_dsr;
    logic [QB:0]      r_quo;

    logic             ge;
    logic [CMP_W-1:0] diff;

    assign ge   = (r_rem >= r_dsr);
    assign diff = r_rem - r_dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QB + 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Top step tests den << QB: a set bit there means the quotient overflows
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= CMP_W'(i_num);
            r_dsr <= CMP_W'(i_den) << QB;
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff;
            end
            r_quo <= {r_quo[QB-1:0], ge};
            r_dsr <= r_dsr >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[QB] ? {QB{1'b1}} : r_quo[QB-1:0];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && $past(r_busy)))
        else $error("divider done without a finished run");

endmodule

// File: rtl/lss_ctrl.sv
// ============================================================================
// Line sensor steering - sequencer and datapath
// Calibration, per-channel scaling and centroid through the shared divider,
// then a three-step multiply-accumulate for the steering law.
// ============================================================================
module lss_ctrl
    import lss_pkg::*;
#(
    parameter int FULL_SCALE = 1000
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_cmd    i_cmd,
    input  t_frame  i_frame,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int SW    = $clog2(FULL_SCALE + 1);
    localparam int QB    = SW + 1;
    localparam int NUM_W = RD_W + SW;
    localparam int SUM_W = SW + 3;
    localparam int WS_W  = SW + 3;
    localparam int DEN_W = (RD_W > SUM_W) ? RD_W : SUM_W;
    localparam int TW    = (SW > THR_W) ? SW : THR_W;
    localparam int UW    = ACC_W - 7;
    localparam logic [SW-1:0] FS_V = SW'(FULL_SCALE);

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    t_frame                  r_rd;
    logic [RD_W-1:0]         r_lo [CHANNELS];
    logic [RD_W-1:0]         r_hi [CHANNELS];
    logic signed [SPD_W-1:0] r_lspd, r_rspd;
    logic signed [POS_W-1:0] r_last, r_pos;
    logic                    r_dark;
    logic [CH_W-1:0]         r_ch;
    logic [1:0]              r_step;
    logic                    r_neg, r_dzero;
    logic signed [WS_W-1:0]  r_wsum;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_found;
    logic signed [ACC_W-1:0] r_acc;
    t_result                 r_res;

    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [QB-1:0]    div_quo;

    function automatic t_drive drive(input logic signed [SPD_W-1:0] spd);
        t_drive           d;
        logic [SPD_W-1:0] mag;
        mag   = spd[SPD_W-1] ? SPD_W'(-spd) : SPD_W'(spd);
        d.dir = !spd[SPD_W-1];
        d.pwm = spd[SPD_W-1] ? mag[PWM_W-1:0] : PWM_W'(SPD_W'(255) - mag);
        return d;
    endfunction

    function automatic logic signed [SPD_W-1:0] clamp_spd(
        input logic signed [UW-1:0] v,
        input logic signed [UW-1:0] m
    );
        logic signed [UW-1:0] c;
        c = v;
        if (v > m) begin
            c = m;
        end else if (v < -m) begin
            c = -m;
        end
        return SPD_W'(c);
    endfunction

    // ---- channel operands --------------------------------------------------
    logic signed [RD_W:0] diff_n, diff_d;
    logic [RD_W-1:0]      n_mag, d_mag;
    logic [NUM_W-1:0]     ch_num;
    logic [WS_W-1:0]      ws_mag;
    logic                 cent_go;

    assign diff_n  = $signed({1'b0, r_rd[r_ch]}) - $signed({1'b0, r_lo[r_ch]});
    assign diff_d  = $signed({1'b0, r_hi[r_ch]}) - $signed({1'b0, r_lo[r_ch]});
    assign n_mag   = diff_n[RD_W] ? RD_W'(-diff_n) : diff_n[RD_W-1:0];
    assign d_mag   = diff_d[RD_W] ? RD_W'(-diff_d) : diff_d[RD_W-1:0];
    assign ch_num  = NUM_W'(n_mag) * NUM_W'(FS_V);
    assign ws_mag  = r_wsum[WS_W-1] ? WS_W'(-r_wsum) : WS_W'(r_wsum);
    assign cent_go = r_found && (r_sum != '0);
    assign div_num = (r_state == ST_CENT) ? NUM_W'(ws_mag) : ch_num;
    assign div_den = (r_state == ST_CENT) ? DEN_W'(r_sum) : DEN_W'(d_mag);

    lss_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QB    (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---- scaled value and accumulation ---------------------------------------
    logic [SW-1:0]          q_sat, s_val;
    logic signed [WS_W-1:0] s_w, w_add;
    logic                   hit;

    assign q_sat = (div_quo > QB'(FS_V)) ? FS_V : div_quo[SW-1:0];
    assign s_val = (r_dzero || (r_neg && (div_quo != '0)))
                 ? (r_dark ? FS_V : '0)
                 : (r_dark ? FS_V - q_sat : q_sat);
    assign s_w   = $signed(WS_W'(s_val));
    assign hit   = (TW'(s_val) <= TW'(i_cfg.line_thr));

    always_comb begin
        case (r_ch)
            CH_W'(0): w_add = -(s_w <<< 1);
            CH_W'(1): w_add = -s_w;
            CH_W'(3): w_add = s_w;
            CH_W'(4): w_add = s_w <<< 1;
            default:  w_add = '0;
        endcase
    end

    // ---- centroid and lost-line position -------------------------------------
    logic [POS_W-1:0]        c_mag;
    logic signed [POS_W-1:0] cent_pos, lost_pos;

    assign c_mag    = POS_W'({div_quo[1:0], 2'b00}) + POS_W'(div_quo[1:0]);
    assign cent_pos = r_wsum[WS_W-1] ? -$signed(c_mag) : $signed(c_mag);
    assign lost_pos = r_last[POS_W-1] ? POS_W'(1) : -POS_W'(1);

    // ---- steering law --------------------------------------------------------
    logic signed [TRM_W-1:0]        t_dif, t_sum, term, j_d;
    logic [GAIN_W-1:0]              gain;
    logic signed [GAIN_W+TRM_W:0]   prod;
    logic signed [ACC_W-1:0]        acc_b;
    logic signed [ACC_W-9:0]        t_q;
    logic signed [UW-1:0]           nl, nr, mx;
    logic [TRM_W-1:0]               j_mag;
    logic                           flip;

    assign t_dif = TRM_W'(r_pos) - TRM_W'(r_last);
    assign t_sum = TRM_W'(r_pos) + TRM_W'(r_last);

    always_comb begin
        case (r_step)
            2'd0: begin
                gain = i_cfg.gain_p;
                term = TRM_W'(r_pos);
            end
            2'd1: begin
                gain = i_cfg.gain_d;
                term = t_dif;
            end
            default: begin
                gain = i_cfg.gain_i;
                term = t_sum;
            end
        endcase
    end

    assign prod  = $signed({1'b0, gain}) * term;
    // Truncate toward zero: bias negative totals before the shift
    assign acc_b = r_acc[ACC_W-1] ? r_acc + ACC_W'(255) : r_acc;
    assign t_q   = acc_b[ACC_W-1:8];
    assign mx    = $signed(UW'(i_cfg.max_speed));
    assign nl    = UW'(r_lspd) - UW'(t_q);
    assign nr    = UW'(r_rspd) + UW'(t_q);
    assign j_d   = t_dif;
    assign j_mag = j_d[TRM_W-1] ? TRM_W'(-j_d) : TRM_W'(j_d);
    assign flip  = (SWT_W'(j_mag) > i_cfg.switch_thr);

    // ---- drive for the speeds that this item reports -------------------------
    logic signed [SPD_W-1:0] spin, dl, dr;

    assign spin = $signed({1'b0, i_cfg.spin_speed});

    always_comb begin
        case (i_cmd)
            CMD_CAL_START: begin
                dl = spin;
                dr = -spin;
            end
            CMD_CAL_FINISH: begin
                dl = '0;
                dr = '0;
            end
            default: begin
                dl = r_lspd;
                dr = r_rspd;
            end
        endcase
    end

    // ---- sequencer -----------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_cmd == CMD_RUN) ? ST_LOAD : ST_CAL;
                end
            end
            ST_CAL:  n_state = ST_DONE;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = (r_ch == CH_W'(CHANNELS - 1)) ? ST_CENT : ST_LOAD;
                end
            end
            ST_CENT: n_state = cent_go ? ST_CDIV : ST_PID;
            ST_CDIV: begin
                if (div_done) begin
                    n_state = ST_PID;
                end
            end
            ST_PID: begin
                if (r_step == 2'd2) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_res_valid = (r_state == ST_DONE);
        div_start   = (r_state == ST_LOAD) || ((r_state == ST_CENT) && cent_go);
    end

    assign o_res = r_res;

    // ---- control state -------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
            r_step  <= '0;
            r_lspd  <= '0;
            r_rspd  <= '0;
            r_last  <= '0;
            r_dark  <= 1'b1;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: r_ch <= '0;
                ST_CAL: begin
                    if (r_cmd == CMD_CAL_START) begin
                        r_lspd <= $signed({1'b0, i_cfg.spin_speed});
                        r_rspd <= -$signed({1'b0, i_cfg.spin_speed});
                    end else if (r_cmd == CMD_CAL_FINISH) begin
                        r_lspd <= $signed({1'b0, i_cfg.fwd_speed});
                        r_rspd <= $signed({1'b0, i_cfg.fwd_speed});
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_ch <= r_ch + CH_W'(1);
                    end
                end
                ST_CENT: r_step <= '0;
                ST_PID:  r_step <= r_step + 2'd1;
                ST_UPD: begin
                    r_lspd <= clamp_spd(nl, mx);
                    r_rspd <= clamp_spd(nr, mx);
                    r_last <= r_pos;
                    r_dark <= r_dark ^ flip;
                end
                default: ;
            endcase
        end
    end

    // ---- datapath ------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_cmd       <= i_cmd;
                    r_rd        <= i_frame;
                    r_res.left  <= drive(dl);
                    r_res.right <= drive(dr);
                    r_wsum      <= '0;
                    r_sum       <= '0;
                    r_found     <= 1'b0;
                end
            end
            ST_CAL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_cmd == CMD_CAL_START) begin
                        r_lo[i] <= r_rd[i];
                        r_hi[i] <= r_rd[i];
                    end else if (r_cmd == CMD_CAL_SAMPLE) begin
                        if (r_rd[i] < r_lo[i]) begin
                            r_lo[i] <= r_rd[i];
                        end
                        if (r_rd[i] > r_hi[i]) begin
                            r_hi[i] <= r_rd[i];
                        end
                    end
                end
                r_res.line_position  <= r_last;
                r_res.line_found     <= 1'b0;
                r_res.dark_line_mode <= r_dark;
            end
            ST_LOAD: begin
                r_neg   <= diff_n[RD_W] ^ diff_d[RD_W];
                r_dzero <= (diff_d == '0);
            end
            ST_DIV: begin
                if (div_done) begin
                    r_wsum  <= r_wsum + w_add;
                    r_sum   <= r_sum + SUM_W'(s_val);
                    r_found <= r_found | hit;
                end
            end
            ST_CENT: begin
                if (!cent_go) begin
                    r_pos <= r_found ? '0 : lost_pos;
                end
            end
            ST_CDIV: begin
                if (div_done) begin
                    r_pos <= cent_pos;
                end
            end
            ST_PID: begin
                if (r_step == 2'd0) begin
                    r_acc <= ACC_W'(prod);
                end else begin
                    r_acc <= r_acc + ACC_W'(prod);
                end
            end
            ST_UPD: begin
                r_res.line_position  <= r_pos;
                r_res.line_found     <= r_found;
                r_res.dark_line_mode <= r_dark ^ flip;
            end
            default: ;
        endcase
    end

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV || r_state == ST_CDIV))
        else $error("divider result outside a divide step");

    a_pos_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last == 5'sd0 || r_last == 5'sd1 || r_last == -5'sd1 ||
         r_last == 5'sd5 || r_last == -5'sd5 ||
         r_last == 5'sd10 || r_last == -5'sd10))
        else $error("line position outside the centroid set");

    a_spd_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_cmd == CMD_RUN) |->
        (r_lspd <= $signed({1'b0, i_cfg.max_speed}) &&
         r_lspd >= -$signed({1'b0, i_cfg.max_speed}) &&
         r_rspd <= $signed({1'b0, i_cfg.max_speed}) &&
         r_rspd >= -$signed({1'b0, i_cfg.max_speed})))
        else $error("motor speed beyond clamp after run frame");

endmodule

// File: rtl/line_sensor_steering_controller_unit.sv
// ============================================================================
// Line sensor steering controller
// Five-channel line sensor to differential motor drive: calibration, scaled
// weighted centroid, polarity tracking and fixed-point steering law.
// ============================================================================
// Each input transaction carries a command in tuser and five ADC readings in
// tdata, and yields exactly one output transaction. Calibration commands pass
// through the calibration state before their result. A run frame scales each
// channel through one shared restoring divider (one quotient bit per cycle),
// divides once more for the centroid when a line is found and the scaled sum
// is nonzero, and runs the steering law through one multiplier, one gain term
// after another. Input ready is high only between frames; a finished result
// sits in the output register, so the next transaction can be taken while it
// waits for the sink. The per-channel calibration minimum and maximum are
// undefined until the first calibration start; run frames before that return
// meaningless scaling. Configuration writes are taken at any clock edge with
// i_cfg_we high and must only come while no transaction is in progress.
module line_sensor_steering_controller_unit
    import lss_pkg::*;
#(
    parameter int FULL_SCALE = 1000
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // Sensor frames in
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // reading_0 [9:0], reading_1 [19:10], reading_2 [29:20], reading_3 [39:30],
    // reading_4 [49:40], zero pad [55:50]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd [1:0]
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // Drive results out
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // left_dir [0], left_pwm [8:1], right_dir [9], right_pwm [17:10],
    // line_position [22:18], line_found [23], dark_line_mode [24], pad [31:25]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_cfg    r_cfg;
    t_frame  frame;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    // ---- configuration registers -------------------------------------------
    // Truncate each write to the register's own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_thr   <= RST_LINE_THR;
            r_cfg.switch_thr <= RST_SWT_THR;
            r_cfg.max_speed  <= RST_MAX_SPD;
            r_cfg.fwd_speed  <= RST_FWD_SPD;
            r_cfg.spin_speed <= RST_SPIN_SPD;
            r_cfg.gain_p     <= RST_GAIN_P;
            r_cfg.gain_d     <= RST_GAIN_D;
            r_cfg.gain_i     <= RST_GAIN_I;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_LINE_THR: r_cfg.line_thr   <= i_cfg_wdata[THR_W-1:0];
                CFG_SWT_THR:  r_cfg.switch_thr <= i_cfg_wdata[SWT_W-1:0];
                CFG_MAX_SPD:  r_cfg.max_speed  <= i_cfg_wdata[SPEED_W-1:0];
                CFG_FWD_SPD:  r_cfg.fwd_speed  <= i_cfg_wdata[SPEED_W-1:0];
                CFG_SPIN_SPD: r_cfg.spin_speed <= i_cfg_wdata[SPEED_W-1:0];
                CFG_GAIN_P:   r_cfg.gain_p     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:   r_cfg.gain_d     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:   r_cfg.gain_i     <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- unpack the sensor frame -------------------------------------------
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            frame[i] = i_s_axis_tdata[i*RD_W +: RD_W];
        end
    end

    // ---- sequencer and datapath --------------------------------------------
    lss_ctrl #(
        .FULL_SCALE (FULL_SCALE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_cmd       (t_cmd'(i_s_axis_tuser)),
        .i_frame     (frame),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // ---- output register ---------------------------------------------------
    // Hold the result until the sink takes it; refill in the same cycle
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {OUT_PAD_W'(0),
                              r_out.dark_line_mode,
                              r_out.line_found,
                              r_out.line_position,
                              r_out.right.pwm,
                              r_out.right.dir,
                              r_out.left.pwm,
                              r_out.left.dir};

endmodule
